>>> hdl/ddaramp_pkg.sv
package ddaramp_pkg;

	// Default widths of the step counts and of the periods.
	localparam int STEP_WIDTH_DEF   = 16;
	localparam int PERIOD_WIDTH_DEF = 16;

	// Register values after reset.
	localparam int PERIOD_MIN_RESET  = 500;
	localparam int PERIOD_MAX_RESET  = 7000;
	localparam int RAMP_LENGTH_RESET = 300;

	// Configuration register indexes.
	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_PERIOD_MIN  = 2'd0;
	localparam cfg_idx_t CFG_PERIOD_MAX  = 2'd1;
	localparam cfg_idx_t CFG_RAMP_LENGTH = 2'd2;

	// Input opcodes.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_SLOT = 1'b1;

endpackage

>>> hdl/two_axis_dda_quadratic_ramp.sv
// Two-axis DDA line interpolator with a quadratic speed ramp.
//
// Input channel (in_valid/in_ready): opcode, x_count, y_count. A load
// (opcode 0) starts a move with the given step counts and answers a result
// whose fields are all zero. A slot request (opcode 1) answers one
// interpolation slot: the axis pulses, the wait after the slot and the
// last-slot flag. A slot request with no move running answers all zeros.
// Output channel (out_valid/out_ready) carries exactly one result per item.
// Configuration channel (cfg_valid/cfg_ready) is always ready; write it
// only while the block is idle.
//
// Loads, idle slots and cruise slots go from the setup state through the
// done state to the output register. A ramp slot runs, after setup, one
// bit-serial squaring pass over STEP_WIDTH bits and then a bit-serial
// scaled division with two steps per period bit, before the done state.
// One item is in work at a time; in_ready is high only while idle.
// The finished result sits in an output register, so a new item is taken
// while the receiver stalls; that item waits at the end if the register is
// still full. Reset clears the move, the output and restores the registers.
module two_axis_dda_quadratic_ramp
	import ddaramp_pkg::*;
#(
	parameter int STEP_WIDTH   = STEP_WIDTH_DEF,
	parameter int PERIOD_WIDTH = PERIOD_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// Configuration writes
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  cfg_idx_t                cfg_index,
	input  logic [((STEP_WIDTH > PERIOD_WIDTH) ? STEP_WIDTH : PERIOD_WIDTH)-1:0] cfg_data,
	// Input items
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    opcode,
	input  logic [STEP_WIDTH-1:0]   x_count,
	input  logic [STEP_WIDTH-1:0]   y_count,
	// Result items
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    slot_valid,
	output logic                    x_pulse,
	output logic                    y_pulse,
	output logic [PERIOD_WIDTH-1:0] slot_period,
	output logic                    last_slot
);

	localparam int SW   = STEP_WIDTH;
	localparam int PW   = PERIOD_WIDTH;
	localparam int DW   = 2 * SW;
	localparam int MAXW = (SW > PW) ? SW : PW;
	localparam int CW   = $clog2(MAXW);

	// Sequencer codes
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SETUP = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_NPREP = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]    state_q;

	// Configuration registers
	logic [PW-1:0] pmin_q;
	logic [PW-1:0] pmax_q;
	logic [SW-1:0] ramp_q;

	// Move state
	logic          active_q;
	logic [SW-1:0] idx_q;
	logic [SW-1:0] total_q;
	logic [SW-1:0] rused_q;
	logic [SW-1:0] xt_q;
	logic [SW-1:0] yt_q;
	logic [SW-1:0] xacc_q;
	logic [SW-1:0] yacc_q;

	// Captured item
	logic          op_q;
	logic [SW-1:0] xc_q;
	logic [SW-1:0] yc_q;

	// Pending result
	logic          res_valid_q;
	logic          res_xp_q;
	logic          res_yp_q;
	logic [PW-1:0] res_period_q;
	logic          res_last_q;

	// Serial arithmetic
	logic [CW-1:0] cnt_q;
	logic          first_q;
	logic          phase_q;
	logic [SW-1:0] mp_den_q;
	logic [SW-1:0] mp_sq_q;
	logic [DW-1:0] mc_den_q;
	logic [DW-1:0] mc_sq_q;
	logic [DW-1:0] den_q;
	logic [DW-1:0] sq_q;
	logic [DW-1:0] rem_q;
	logic [PW-1:0] quo_q;
	logic [PW-1:0] rng_q;

	// Load decode
	logic [SW-1:0] ld_total;
	logic [SW-1:0] ld_half;
	logic [SW-1:0] ld_ramp;
	logic          ld_clamp;

	// Slot decode
	logic [SW:0]   sum_x;
	logic [SW:0]   sum_y;
	logic [SW:0]   dif_x;
	logic [SW:0]   dif_y;
	logic          xp;
	logic          yp;
	logic [SW:0]   idx_p1;
	logic          last;
	logic          ramp_up;
	logic [SW:0]   ir_sum;
	logic          flat;
	logic [SW-1:0] kval;

	// Division step
	logic [DW:0]   r_dbl;
	logic [DW:0]   r_add;
	logic [DW:0]   r_in;
	logic [DW:0]   r_sub;
	logic          r_ge;
	logic [DW-1:0] r_nx;
	logic          out_free;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_free  = !out_valid || out_ready;

	// Ramp length for a new move: clamped to half the total, at least one when clamped on a non-empty move.
	always_comb begin
		ld_total = (xc_q > yc_q) ? xc_q : yc_q;
		ld_half  = ld_total >> 1;
		ld_clamp = {ramp_q, 1'b0} > {1'b0, ld_total};
		if (!ld_clamp) begin
			ld_ramp = ramp_q;
		end else if (ld_half == '0 && ld_total != '0) begin
			ld_ramp = SW'(1);
		end else begin
			ld_ramp = ld_half;
		end
	end

	// DDA accumulators, slot position and ramp phase.
	always_comb begin
		sum_x   = {1'b0, xacc_q} + {1'b0, xt_q};
		sum_y   = {1'b0, yacc_q} + {1'b0, yt_q};
		dif_x   = sum_x - {1'b0, total_q};
		dif_y   = sum_y - {1'b0, total_q};
		xp      = sum_x >= {1'b0, total_q};
		yp      = sum_y >= {1'b0, total_q};
		idx_p1  = {1'b0, idx_q} + (SW+1)'(1);
		last    = idx_p1 >= {1'b0, total_q};
		ramp_up = idx_q < rused_q;
		ir_sum  = {1'b0, idx_q} + {1'b0, rused_q};
		flat    = (!ramp_up && ir_sum < {1'b0, total_q}) || rused_q == '0 || pmin_q > pmax_q;
		kval    = ramp_up ? (rused_q - idx_q) : (total_q - idx_q);
	end

	// One restoring step of floor(range * n / den): the doubling step on
	// phase zero, the conditional add of n on phase one.
	always_comb begin
		r_dbl = {rem_q, 1'b0};
		r_add = {1'b0, rem_q} + (rng_q[PW-1] ? {1'b0, sq_q} : '0);
		r_in  = phase_q ? r_add : r_dbl;
		r_sub = r_in - {1'b0, den_q};
		r_ge  = r_in >= {1'b0, den_q};
		r_nx  = r_ge ? r_sub[DW-1:0] : r_in[DW-1:0];
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pmin_q <= PW'(PERIOD_MIN_RESET);
			pmax_q <= PW'(PERIOD_MAX_RESET);
			ramp_q <= SW'(RAMP_LENGTH_RESET);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PERIOD_MIN:  pmin_q <= cfg_data[PW-1:0];
				CFG_PERIOD_MAX:  pmax_q <= cfg_data[PW-1:0];
				CFG_RAMP_LENGTH: ramp_q <= cfg_data[SW-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer and move state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			active_q <= 1'b0;
			idx_q    <= '0;
			total_q  <= '0;
			rused_q  <= '0;
			xt_q     <= '0;
			yt_q     <= '0;
			xacc_q   <= '0;
			yacc_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					if (op_q == OP_LOAD) begin
						xt_q     <= xc_q;
						yt_q     <= yc_q;
						total_q  <= ld_total;
						rused_q  <= ld_ramp;
						idx_q    <= '0;
						xacc_q   <= '0;
						yacc_q   <= '0;
						active_q <= (ld_total != '0);
						state_q  <= ST_DONE;
					end else if (!active_q) begin
						state_q <= ST_DONE;
					end else begin
						xacc_q <= xp ? dif_x[SW-1:0] : sum_x[SW-1:0];
						yacc_q <= yp ? dif_y[SW-1:0] : sum_y[SW-1:0];
						idx_q  <= idx_p1[SW-1:0];
						if (last) begin
							active_q <= 1'b0;
						end
						state_q <= flat ? ST_DONE : ST_MUL;
					end
				end
				ST_MUL: begin
					if (cnt_q == CW'(SW - 1)) begin
						state_q <= ST_NPREP;
					end
				end
				ST_NPREP: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (phase_q && cnt_q == CW'(PW - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item capture, result fields and the serial datapath.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_q <= opcode;
			xc_q <= x_count;
			yc_q <= y_count;
		end

		unique case (state_q)
			ST_SETUP: begin
				res_valid_q  <= 1'b0;
				res_xp_q     <= 1'b0;
				res_yp_q     <= 1'b0;
				res_last_q   <= 1'b0;
				res_period_q <= '0;
				if (op_q == OP_SLOT && active_q) begin
					res_valid_q  <= 1'b1;
					res_xp_q     <= xp;
					res_yp_q     <= yp;
					res_last_q   <= last;
					res_period_q <= pmin_q;
				end
				// Operands of the two squarings and the range to scale.
				first_q  <= ramp_up;
				mp_den_q <= rused_q;
				mc_den_q <= DW'(rused_q);
				mp_sq_q  <= kval;
				mc_sq_q  <= DW'(kval);
				den_q    <= '0;
				sq_q     <= '0;
				rng_q    <= pmax_q - pmin_q;
				cnt_q    <= '0;
			end
			ST_MUL: begin
				// Shift-add squaring, one multiplier bit per cycle.
				if (mp_den_q[0]) begin
					den_q <= den_q + mc_den_q;
				end
				if (mp_sq_q[0]) begin
					sq_q <= sq_q + mc_sq_q;
				end
				mp_den_q <= mp_den_q >> 1;
				mp_sq_q  <= mp_sq_q >> 1;
				mc_den_q <= mc_den_q << 1;
				mc_sq_q  <= mc_sq_q << 1;
				cnt_q    <= cnt_q + CW'(1);
			end
			ST_NPREP: begin
				// On the way up the numerator is R*R minus the remaining square.
				if (first_q) begin
					sq_q <= den_q - sq_q;
				end
				rem_q   <= '0;
				quo_q   <= '0;
				phase_q <= 1'b0;
				cnt_q   <= '0;
			end
			ST_DIV: begin
				rem_q <= r_nx;
				if (phase_q) begin
					quo_q <= quo_q + PW'(r_ge);
					rng_q <= rng_q << 1;
					cnt_q <= cnt_q + CW'(1);
				end else begin
					quo_q <= {quo_q[PW-2:0], r_ge};
				end
				phase_q <= !phase_q;
			end
			ST_FIN: begin
				res_period_q <= pmax_q - quo_q;
			end
			default: ;
		endcase
	end

	// Output register: filled from the pending result when free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			slot_valid  <= res_valid_q;
			x_pulse     <= res_xp_q;
			y_pulse     <= res_yp_q;
			slot_period <= res_period_q;
			last_slot   <= res_last_q;
		end
	end

endmodule

>>> tb/dda_slot_checker.sv
`timescale 1ns / 100ps

// Watches the configuration, input and result channels of the two-axis DDA
// ramp. It keeps its own copy of the registers and of the move state, works
// out the slot each accepted item should produce and compares the results in
// order.
module dda_slot_checker
	import ddaramp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  cfg_idx_t    cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        opcode,
	input  logic [15:0] x_count,
	input  logic [15:0] y_count,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        slot_valid,
	input  logic        x_pulse,
	input  logic        y_pulse,
	input  logic [15:0] slot_period,
	input  logic        last_slot,
	output int          slots_due,
	output int          fail_count
);

	typedef struct packed {
		logic        active;
		logic        x_step;
		logic        y_step;
		logic [15:0] period;
		logic        last;
	} slot_t;

	// Mirrored registers.
	logic [15:0] cruise_period;
	logic [15:0] start_period;
	logic [15:0] ramp_request;

	// Mirrored move state.
	logic        move_on;
	logic [15:0] slot_idx;
	logic [15:0] slot_cnt;
	logic [15:0] ramp_len;
	logic [15:0] x_steps;
	logic [15:0] y_steps;
	logic [16:0] x_acc;
	logic [16:0] y_acc;

	slot_t slots_expected[$];

	// Prints one mismatch line and counts it.
	task automatic report(input string what, input longint want, input longint got);
		$display("%0t: mismatch on %s, expected %0d, got %0d", $realtime, what, want, got);
		fail_count++;
	endtask

	// Start period minus the exact floor of span*num/den, never below the
	// cruise period and saturated to 16 bits.
	function automatic logic [15:0] ramp_wait(input longint num, input longint den);
		longint span;
		longint prod;
		longint cut;
		longint p;
		span = longint'(start_period) - longint'(cruise_period);
		prod = span * num;
		if (prod >= 0) begin
			cut = prod / den;
		end else begin
			cut = -((-prod + den - 1) / den);
		end
		p = longint'(start_period) - cut;
		if (p < longint'(cruise_period)) begin
			p = longint'(cruise_period);
		end
		if (p > 65535) begin
			p = 65535;
		end
		return p[15:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		slot_t  got;
		slot_t  want;
		longint i;
		longint rr;
		longint den;
		longint k;
		longint d;
		longint tot;
		if (!arst_n) begin
			cruise_period = 16'(PERIOD_MIN_RESET);
			start_period  = 16'(PERIOD_MAX_RESET);
			ramp_request  = 16'(RAMP_LENGTH_RESET);
			move_on  = 1'b0;
			slot_idx = '0;
			slot_cnt = '0;
			ramp_len = '0;
			x_steps  = '0;
			y_steps  = '0;
			x_acc    = '0;
			y_acc    = '0;
			slots_expected.delete();
			fail_count = 0;
			slots_due <= 0;
		end else begin
			// Register writes take effect at the transfer.
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PERIOD_MIN:  cruise_period = cfg_data;
					CFG_PERIOD_MAX:  start_period  = cfg_data;
					CFG_RAMP_LENGTH: ramp_request  = cfg_data;
					default: ;
				endcase
			end

			// Each result transfer is compared with the oldest expected slot.
			if (out_valid && out_ready) begin
				got = '{slot_valid, x_pulse, y_pulse, slot_period, last_slot};
				if (slots_expected.size() == 0) begin
					report("result with nothing pending", 0, 1);
				end else begin
					want = slots_expected.pop_front();
					if (got.active !== want.active) report("slot_valid", want.active, got.active);
					if (got.x_step !== want.x_step) report("x_pulse", want.x_step, got.x_step);
					if (got.y_step !== want.y_step) report("y_pulse", want.y_step, got.y_step);
					if (got.period !== want.period) report("slot_period", want.period, got.period);
					if (got.last !== want.last) report("last_slot", want.last, got.last);
				end
			end

			// Each input transfer yields exactly one expected result.
			if (in_valid && in_ready) begin
				want = '0;
				if (opcode == OP_LOAD) begin
					// A load aborts any move and clamps the ramp to half the move.
					tot = (x_count > y_count) ? longint'(x_count) : longint'(y_count);
					rr = longint'(ramp_request);
					if (rr * 2 > tot) begin
						rr = tot / 2;
						if (rr == 0 && tot > 0) begin
							rr = 1;
						end
					end
					x_steps  = x_count;
					y_steps  = y_count;
					slot_cnt = tot[15:0];
					ramp_len = rr[15:0];
					slot_idx = '0;
					x_acc    = '0;
					y_acc    = '0;
					move_on  = (tot != 0);
				end else if (move_on) begin
					// Period from the ramp phase, then one DDA step per axis.
					i   = longint'(slot_idx);
					rr  = longint'(ramp_len);
					tot = longint'(slot_cnt);
					den = rr * rr;
					if (i < rr) begin
						k = rr - i;
						want.period = ramp_wait(den - k * k, den);
					end else if (i + rr < tot) begin
						want.period = cruise_period;
					end else begin
						d = tot - i;
						if (d > rr) begin
							d = rr;
						end
						want.period = (den == 0) ? cruise_period : ramp_wait(d * d, den);
					end
					x_acc = x_acc + x_steps;
					if (x_acc >= slot_cnt) begin
						x_acc = x_acc - slot_cnt;
						want.x_step = 1'b1;
					end
					y_acc = y_acc + y_steps;
					if (y_acc >= slot_cnt) begin
						y_acc = y_acc - slot_cnt;
						want.y_step = 1'b1;
					end
					want.active = 1'b1;
					if (i + 1 >= tot) begin
						want.last = 1'b1;
						move_on = 1'b0;
					end
					slot_idx = slot_idx + 16'd1;
				end
				slots_expected.push_back(want);
			end
			slots_due <= slots_expected.size();
		end
	end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb
	import ddaramp_pkg::*;
();

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	cfg_idx_t    cfg_index = CFG_PERIOD_MIN;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        opcode = OP_LOAD;
	logic [15:0] x_count = '0;
	logic [15:0] y_count = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        slot_valid;
	logic        x_pulse;
	logic        y_pulse;
	logic [15:0] slot_period;
	logic        last_slot;
	int          slots_due;
	int          fail_count;

	// When set, neither side idles.
	logic        calm = 1'b0;

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	two_axis_dda_quadratic_ramp #(
		.STEP_WIDTH(16),
		.PERIOD_WIDTH(16)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.x_count(x_count),
		.y_count(y_count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.slot_valid(slot_valid),
		.x_pulse(x_pulse),
		.y_pulse(y_pulse),
		.slot_period(slot_period),
		.last_slot(last_slot)
	);

	dda_slot_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.x_count(x_count),
		.y_count(y_count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.slot_valid(slot_valid),
		.x_pulse(x_pulse),
		.y_pulse(y_pulse),
		.slot_period(slot_period),
		.last_slot(last_slot),
		.slots_due(slots_due),
		.fail_count(fail_count)
	);

	// The receiver stalls at random, with a chance of 30 percent, unless calm.
	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 30);
	end

	// Presents one item after a random gap and holds it until the transfer.
	// Valid is left high so that the next item can follow without a gap.
	task automatic send_item(input logic op, input logic [15:0] xc, input logic [15:0] yc);
		if (!calm) begin
			while ($urandom_range(99) < 30) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		opcode   <= op;
		x_count  <= xc;
		y_count  <= yc;
		do @(posedge clk); while (!in_ready);
	endtask

	// Holds off the sender until every expected result has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (slots_due != 0);
	endtask

	// Writes all three registers back to back; call only while drained.
	task automatic write_regs(input logic [15:0] pmin, input logic [15:0] pmax,
			input logic [15:0] rlen);
		cfg_idx_t    idx[3] = '{CFG_PERIOD_MIN, CFG_PERIOD_MAX, CFG_RAMP_LENGTH};
		logic [15:0] val[3];
		val = '{pmin, pmax, rlen};
		cfg_valid <= 1'b1;
		for (int n = 0; n < 3; n++) begin
			cfg_index <= idx[n];
			cfg_data  <= val[n];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	// Loads a move and requests a number of slots with random unused counts.
	task automatic run_move(input logic [15:0] xc, input logic [15:0] yc, input int slots);
		send_item(OP_LOAD, xc, yc);
		repeat (slots) send_item(OP_SLOT, 16'($urandom), 16'($urandom));
	endtask

	// An empty load leaves no move running, then everything drains.
	task automatic end_phase();
		send_item(OP_LOAD, '0, '0);
		wait_drained();
	endtask

	initial begin
		int total;
		int slots;
		int xs;
		int ys;
		int roll;
		int sent;
		logic [15:0] lo;
		logic [15:0] hi;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset register values.
		send_item(OP_SLOT, 16'hFFFF, 16'hFFFF);   // slot request with no move
		run_move(16'd0, 16'd0, 1);                // empty move stays idle
		run_move(16'd1, 16'd0, 2);                // one slot, then idle again
		run_move(16'd3, 16'd1, 3);                // ramp clamped to one slot
		run_move(16'hFFFF, 16'hFFFF, 2);          // largest counts, aborted below
		end_phase();

		// Zero ramp: every slot cruises, here at the smallest period.
		write_regs(16'd0, 16'hFFFF, 16'd0);
		run_move(16'd4, 16'd3, 4);
		end_phase();

		// Inverted limits: every ramp slot answers the cruise period.
		write_regs(16'd900, 16'd100, 16'd2);
		run_move(16'd5, 16'd2, 5);
		end_phase();

		// Widest span with the largest ramp request.
		write_regs(16'd0, 16'hFFFF, 16'hFFFF);
		run_move(16'd6, 16'd5, 6);

		// Random phases, each with its own register setting.
		for (int phase = 0; phase < 7; phase++) begin
			end_phase();
			lo = 16'($urandom_range(0, 2000));
			case (phase)
				0: write_regs(16'd500, 16'd7000, 16'd300);
				1: write_regs(lo, 16'(lo + $urandom_range(0, 20000)), 16'($urandom_range(1, 12)));
				2: write_regs(lo, 16'($urandom), 16'd0);
				3: begin
					hi = 16'($urandom_range(0, 30000));
					write_regs(16'(hi + $urandom_range(1, 30000)), hi, 16'($urandom_range(1, 20)));
				end
				4: write_regs(16'd0, 16'hFFFF, 16'hFFFF);
				5: begin
					hi = 16'($urandom);
					write_regs(hi, hi, 16'($urandom_range(0, 30)));
				end
				default: write_regs(16'($urandom), 16'($urandom), 16'($urandom));
			endcase
			calm <= (phase == 1);
			sent = 0;
			while (sent < 35) begin
				roll = $urandom_range(99);
				if (roll < 80) begin
					// Well-formed move: load, then slots up to its end and sometimes past.
					total = ($urandom_range(9) == 0) ? $urandom_range(41, 150)
						: $urandom_range(1, 40);
					xs = total;
					ys = $urandom_range(0, total);
					if ($urandom_range(1) == 1) begin
						ys = total;
						xs = $urandom_range(0, total);
					end
					slots = ($urandom_range(4) == 0) ? $urandom_range(0, total)
						: total + $urandom_range(0, 1);
					if ($urandom_range(19) == 0) begin
						wait_drained();
					end
					run_move(16'(xs), 16'(ys), slots);
					sent += slots + 1;
				end else if (roll < 92) begin
					// Full-range counts, aborted after a few slots.
					slots = $urandom_range(0, 3);
					run_move(16'($urandom), 16'($urandom), slots);
					sent += slots + 1;
				end else begin
					send_item(1'($urandom_range(1)), 16'($urandom), 16'($urandom));
					sent++;
				end
			end
		end
		end_phase();
		calm <= 1'b0;

		// Let any late result show up before the verdict.
		repeat (80) @(posedge clk);
		if (fail_count == 0 && slots_due == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Hard limit on the run.
	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
